// ===== sv/ps2mpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ps2mpt_pkg;

  // Command codes on the input tuser field
  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_POLL    = 2'd1,
    FUNC_RECLAMP = 2'd2,
    FUNC_GET     = 2'd3
  } func_e;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_MOVE    = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_RECLAMP = 2'd2,
    CMD_GET     = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [2:0] btn;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
  } bounds_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic poll_fire;
    logic result_fire;
    logic dirty;
  } back_status_t;

  // Controller status and packet byte bits
  localparam int unsigned ST_FULL_BIT = 0;
  localparam int unsigned ST_AUX_BIT  = 5;
  localparam int unsigned SYNC_BIT    = 3;
  localparam logic [7:0]  OVF_MASK    = 8'hC0;
  localparam logic [2:0]  BTN_MASK    = 3'h7;

  // Configuration register indexes
  localparam logic [7:0] CFG_MIN_X = 8'd0;
  localparam logic [7:0] CFG_MIN_Y = 8'd1;
  localparam logic [7:0] CFG_MAX_X = 8'd2;
  localparam logic [7:0] CFG_MAX_Y = 8'd3;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 136;

endpackage

`default_nettype wire

// ===== sv/ps2mpt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ps2mpt_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [ps2mpt_pkg::IN_DATA_W-1:0]   in_data_i,
  input  wire logic [1:0]                         in_func_i,
  input  wire logic                               q_ready_i,
  output logic                                    push_o,
  output ps2mpt_pkg::cmd_t                        push_cmd_o
);

  logic [1:0] idx_q, idx_d;
  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;

  logic       accept;
  logic [7:0] status;
  logic [7:0] dbyte;
  logic       for_mouse;
  logic       emit;
  ps2mpt_pkg::func_e func;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign status     = in_data_i[7:0];
  assign dbyte      = in_data_i[15:8];
  assign func       = ps2mpt_pkg::func_e'(in_func_i);
  assign for_mouse  = status[ps2mpt_pkg::ST_FULL_BIT] && status[ps2mpt_pkg::ST_AUX_BIT];

  always_comb begin
    idx_d   = idx_q;
    held0_d = held0_q;
    held1_d = held1_q;
    emit    = 1'b0;
    push_cmd_o.kind = ps2mpt_pkg::CMD_MOVE;
    push_cmd_o.dx   = held1_q;
    push_cmd_o.dy   = dbyte;
    push_cmd_o.btn  = held0_q[2:0] & ps2mpt_pkg::BTN_MASK;
    case (func)
      ps2mpt_pkg::FUNC_BYTE: begin
        if (for_mouse) begin
          if (idx_q == 2'd0) begin
            // resync: drop a first byte without the sync bit
            if (dbyte[ps2mpt_pkg::SYNC_BIT]) begin
              held0_d = dbyte;
              idx_d   = 2'd1;
            end
          end else if (idx_q == 2'd1) begin
            held1_d = dbyte;
            idx_d   = 2'd2;
          end else begin
            idx_d = 2'd0;
            emit  = (held0_q & ps2mpt_pkg::OVF_MASK) == 8'h00;
          end
        end
      end
      ps2mpt_pkg::FUNC_POLL: begin
        emit = 1'b1;
        push_cmd_o.kind = ps2mpt_pkg::CMD_POLL;
      end
      ps2mpt_pkg::FUNC_RECLAMP: begin
        emit = 1'b1;
        push_cmd_o.kind = ps2mpt_pkg::CMD_RECLAMP;
      end
      ps2mpt_pkg::FUNC_GET: begin
        emit = 1'b1;
        push_cmd_o.kind = ps2mpt_pkg::CMD_GET;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (accept) begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held0_q <= held0_d;
      held1_q <= held1_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ps2mpt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ps2mpt_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire ps2mpt_pkg::cmd_t      push_cmd_i,
  input  wire logic                  pop_i,
  output ps2mpt_pkg::cmd_t           head_o,
  output ps2mpt_pkg::q_status_t      status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  ps2mpt_pkg::cmd_t slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = cnt_q == FULL;
  assign status_o.empty = cnt_q == '0;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == LAST) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == LAST) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ps2mpt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ps2mpt_back #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cmd_valid_i,
  input  wire ps2mpt_pkg::cmd_t                    cmd_i,
  output logic                                     pop_o,
  input  wire ps2mpt_pkg::bounds_t                 bounds_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [ps2mpt_pkg::OUT_DATA_W-1:0]        out_data_o,
  output ps2mpt_pkg::back_status_t                 status_o
);

  localparam int unsigned WW = 34;
  localparam logic signed [WW-1:0] PMAX = WW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] PMIN = -PMAX - WW'(1);

  logic signed [POS_WIDTH-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [31:0] adx_q, adx_d, ady_q, ady_d;
  logic [2:0]  btn_q, btn_d;
  logic        dirty_q, dirty_d;
  logic        ovalid_q, ovalid_d;
  logic [ps2mpt_pkg::OUT_DATA_W-1:0] odata_q;

  logic        needs_out, fire, fire_out;
  logic signed [WW-1:0] dx_w, dy_w, vx, vy;
  logic signed [POS_WIDTH-1:0] fx, fy;
  logic signed [31:0] px32, py32;

  function automatic logic signed [POS_WIDTH-1:0] fit(input logic signed [WW-1:0] v,
                                                      input logic signed [31:0] lo32,
                                                      input logic signed [31:0] hi32);
    logic signed [WW-1:0] lo, hi, c;
    lo = WW'(lo32);
    hi = WW'(hi32);
    c  = v;
    if (hi >= lo) begin
      if (v < lo) begin
        c = lo;
      end else if (v > hi) begin
        c = hi;
      end
    end
    if (c < PMIN) begin
      c = PMIN;
    end else if (c > PMAX) begin
      c = PMAX;
    end
    return c[POS_WIDTH-1:0];
  endfunction

  assign needs_out = (cmd_i.kind == ps2mpt_pkg::CMD_POLL) || (cmd_i.kind == ps2mpt_pkg::CMD_GET);
  assign fire      = cmd_valid_i && (!needs_out || !ovalid_q || out_ready_i);
  assign fire_out  = fire && needs_out;
  assign pop_o     = fire;

  assign dx_w = WW'(signed'(cmd_i.dx));
  assign dy_w = WW'(signed'(cmd_i.dy));

  // Move adds dx and subtracts dy; reclamp refits the cursor as it stands
  assign vx = (cmd_i.kind == ps2mpt_pkg::CMD_MOVE) ? WW'(cx_q) + dx_w : WW'(cx_q);
  assign vy = (cmd_i.kind == ps2mpt_pkg::CMD_MOVE) ? WW'(cy_q) - dy_w : WW'(cy_q);
  assign fx = fit(vx, bounds_i.min_x, bounds_i.max_x);
  assign fy = fit(vy, bounds_i.min_y, bounds_i.max_y);

  assign px32 = 32'(cx_q);
  assign py32 = 32'(cy_q);

  always_comb begin
    cx_d    = cx_q;
    cy_d    = cy_q;
    adx_d   = adx_q;
    ady_d   = ady_q;
    btn_d   = btn_q;
    dirty_d = dirty_q;
    if (fire) begin
      case (cmd_i.kind)
        ps2mpt_pkg::CMD_MOVE: begin
          cx_d    = fx;
          cy_d    = fy;
          adx_d   = adx_q + 32'(signed'(cmd_i.dx));
          ady_d   = ady_q - 32'(signed'(cmd_i.dy));
          btn_d   = cmd_i.btn;
          dirty_d = 1'b1;
        end
        ps2mpt_pkg::CMD_RECLAMP: begin
          cx_d = fx;
          cy_d = fy;
        end
        ps2mpt_pkg::CMD_POLL: begin
          adx_d   = '0;
          ady_d   = '0;
          dirty_d = 1'b0;
        end
        default: begin
          dirty_d = dirty_q;
        end
      endcase
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (fire_out) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      adx_q    <= '0;
      ady_q    <= '0;
      btn_q    <= '0;
      dirty_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      adx_q    <= adx_d;
      ady_q    <= ady_d;
      btn_q    <= btn_d;
      dirty_q  <= dirty_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_out) begin
      odata_q <= {4'b0000, dirty_q, btn_q, ady_q, adx_q, py32, px32};
    end
  end

  assign out_valid_o          = ovalid_q;
  assign out_data_o           = odata_q;
  assign status_o.poll_fire   = fire && (cmd_i.kind == ps2mpt_pkg::CMD_POLL);
  assign status_o.result_fire = fire_out;
  assign status_o.dirty       = dirty_q;

endmodule

`default_nettype wire

// ===== sv/ps2_mouse_packet_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel        Dir  Handshake                   Payload
// s_axis         in   s_axis_tvalid/tready        tdata: ctrl_status, data_byte; tuser: func
// m_axis         out  m_axis_tvalid/tready        tdata: pos_x .. had_motion
// cfg            in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
// One item per cycle is taken in while the queue has room.
// A result for an accepted poll or get reaches m_axis through the command queue
// and then the output register.
// Reset clears all control and tracker state at once; there is no clearing pass.
// A stalled m_axis holds the back end only for poll and get; the queue absorbs
// the front end until it fills, then s_axis_tready drops.

module ps2_mouse_packet_tracker #(
  parameter int unsigned POS_WIDTH   = 32,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [15:0]   s_axis_tdata,   // [7:0] ctrl_status, [15:8] data_byte
  input  wire logic [1:0]    s_axis_tuser,   // [1:0] func
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] delta_x_sum, [127:96] delta_y_sum,
  // [130:128] button_bits, [131] had_motion, [135:132] zero
  output logic [135:0]       m_axis_tdata,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [7:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  ps2mpt_pkg::bounds_t      bounds_q;
  ps2mpt_pkg::cmd_t         push_cmd, head_cmd;
  ps2mpt_pkg::q_status_t    q_st;
  ps2mpt_pkg::back_status_t back_st;
  logic                     push, pop;

  // Bound registers; writes always complete, unknown indexes drop silently
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q.min_x <= 32'sd0;
      bounds_q.min_y <= 32'sd0;
      bounds_q.max_x <= -32'sd1;
      bounds_q.max_y <= -32'sd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ps2mpt_pkg::CFG_MIN_X: bounds_q.min_x <= cfg_data_i;
        ps2mpt_pkg::CFG_MIN_Y: bounds_q.min_y <= cfg_data_i;
        ps2mpt_pkg::CFG_MAX_X: bounds_q.max_x <= cfg_data_i;
        ps2mpt_pkg::CFG_MAX_Y: bounds_q.max_y <= cfg_data_i;
        default: begin
          bounds_q <= bounds_q;
        end
      endcase
    end
  end

  // Front end: filter controller bytes, assemble packets, classify commands
  ps2mpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_func_i  (s_axis_tuser),
    .q_ready_i  (!q_st.full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Short queue decouples packet assembly from cursor update
  ps2mpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .status_o   (q_st)
  );

  // Back end: move, clamp, accumulate, and answer poll and get
  ps2mpt_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_st.empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .bounds_i    (bounds_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .status_o    (back_st)
  );

  // A new result is only loaded when the output register is free or draining
  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.result_fire |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a held output item");

  // A poll clears the motion flag for the next cycle
  a_poll_clears_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.poll_fire |=> !back_st.dirty)
    else $error("dirty flag survived a poll");

  // Queue is never full and empty together
  a_queue_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_st.full && q_st.empty))
    else $error("queue status inconsistent");

  // The back end never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_st.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== tb/ps2mpt_report_checker.sv =====
`timescale 1ns / 1ps

module ps2mpt_report_checker #(
  parameter int unsigned POS_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [15:0]  s_tdata_i,   // [7:0] ctrl_status, [15:8] data_byte
  input  logic [1:0]   s_tuser_i,   // [1:0] func
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [135:0] m_tdata_i,   // pos_x, pos_y, delta_x_sum, delta_y_sum, buttons, motion
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int           outstanding_o,
  output int           mismatches_o,
  output int           reports_o,
  output int           moves_o,
  output int           drops_o
);

  localparam longint PosTop    = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
  localparam longint PosBottom = -PosTop - 1;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] dx_sum;
    logic [31:0] dy_sum;
    logic [2:0]  buttons;
    logic        motion;
  } mouse_report_t;

  mouse_report_t report_q[$];

  // Predicted tracker state
  logic signed [31:0] lo_x, lo_y, hi_x, hi_y;
  logic [1:0]         pkt_pos;
  logic [7:0]         pkt_head[2];
  logic signed [31:0] cur_x, cur_y;
  logic [31:0]        sum_dx, sum_dy;
  logic [2:0]         btn_state;
  logic               motion;

  int mismatch_total, report_total, move_total, drop_total;

  assign mismatches_o = mismatch_total;
  assign reports_o    = report_total;
  assign moves_o      = move_total;
  assign drops_o      = drop_total;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_total++;
  endtask

  // Window clamp first (only when hi >= lo), then saturate to the cursor width.
  function automatic logic [31:0] clamp_axis(input longint v, input longint lo,
                                             input longint hi);
    longint r;
    r = v;
    if (hi >= lo) begin
      if (r < lo) r = lo;
      if (r > hi) r = hi;
    end
    if (r < PosBottom) r = PosBottom;
    if (r > PosTop) r = PosTop;
    return r[31:0];
  endfunction

  task automatic apply_item(input ps2mpt_pkg::func_e op, input logic [7:0] status,
                            input logic [7:0] data);
    longint        step_x, step_y;
    mouse_report_t rep;
    case (op)
      ps2mpt_pkg::FUNC_BYTE: begin
        if (status[ps2mpt_pkg::ST_FULL_BIT] && status[ps2mpt_pkg::ST_AUX_BIT] &&
            (pkt_pos != 2'd0 || data[ps2mpt_pkg::SYNC_BIT])) begin
          if (pkt_pos < 2'd2) begin
            pkt_head[pkt_pos[0]] = data;
            pkt_pos++;
          end else begin
            pkt_pos = 2'd0;
            if ((pkt_head[0] & ps2mpt_pkg::OVF_MASK) != 8'h00) begin
              drop_total++;
            end else begin
              step_x    = longint'($signed(pkt_head[1]));
              step_y    = longint'($signed(data));
              cur_x     = clamp_axis(longint'(cur_x) + step_x, lo_x, hi_x);
              cur_y     = clamp_axis(longint'(cur_y) - step_y, lo_y, hi_y);
              sum_dx    = sum_dx + step_x[31:0];
              sum_dy    = sum_dy - step_y[31:0];
              btn_state = pkt_head[0][2:0] & ps2mpt_pkg::BTN_MASK;
              motion    = 1'b1;
              move_total++;
            end
          end
        end
      end
      ps2mpt_pkg::FUNC_RECLAMP: begin
        cur_x = clamp_axis(longint'(cur_x), lo_x, hi_x);
        cur_y = clamp_axis(longint'(cur_y), lo_y, hi_y);
      end
      default: begin
        rep = '{pos_x: cur_x, pos_y: cur_y, dx_sum: sum_dx, dy_sum: sum_dy,
                buttons: btn_state, motion: motion};
        report_q.push_back(rep);
        if (op == ps2mpt_pkg::FUNC_POLL) begin
          sum_dx = '0;
          sum_dy = '0;
          motion = 1'b0;
        end
      end
    endcase
  endtask

  task automatic check_report(input logic [135:0] word);
    mouse_report_t want;
    report_total++;
    if (report_q.size() == 0) begin
      flag_mismatch("result with nothing pending", word[31:0], '0);
      return;
    end
    want = report_q.pop_front();
    if (word[31:0] !== want.pos_x) flag_mismatch("pos_x", word[31:0], want.pos_x);
    if (word[63:32] !== want.pos_y) flag_mismatch("pos_y", word[63:32], want.pos_y);
    if (word[95:64] !== want.dx_sum) flag_mismatch("delta_x_sum", word[95:64], want.dx_sum);
    if (word[127:96] !== want.dy_sum) begin
      flag_mismatch("delta_y_sum", word[127:96], want.dy_sum);
    end
    if (word[130:128] !== want.buttons) begin
      flag_mismatch("button_bits", 32'(word[130:128]), 32'(want.buttons));
    end
    if (word[131] !== want.motion) begin
      flag_mismatch("had_motion", 32'(word[131]), 32'(want.motion));
    end
    if (word[135:132] !== 4'h0) flag_mismatch("tdata padding", 32'(word[135:132]), '0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_x          = '0;
      lo_y          = '0;
      hi_x          = '1;
      hi_y          = '1;
      pkt_pos       = 2'd0;
      pkt_head[0]   = '0;
      pkt_head[1]   = '0;
      cur_x         = '0;
      cur_y         = '0;
      sum_dx        = '0;
      sum_dy        = '0;
      btn_state     = '0;
      motion        = 1'b0;
      report_q.delete();
      outstanding_o <= 0;
    end else begin
      // Results leave only after their command has passed the queue and output register, so check first.
      if (m_tvalid_i && m_tready_i) check_report(m_tdata_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ps2mpt_pkg::CFG_MIN_X: lo_x = cfg_data_i;
          ps2mpt_pkg::CFG_MIN_Y: lo_y = cfg_data_i;
          ps2mpt_pkg::CFG_MAX_X: hi_x = cfg_data_i;
          ps2mpt_pkg::CFG_MAX_Y: hi_y = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_item(ps2mpt_pkg::func_e'(s_tuser_i), s_tdata_i[7:0], s_tdata_i[15:8]);
      end
      outstanding_o <= report_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned PhaseCount = 10;
  localparam int unsigned PhaseItems = 160;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata;   // [7:0] ctrl_status, [15:8] data_byte
  logic [1:0]   s_axis_tuser;   // [1:0] func
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [31:0] pos_x, [63:32] pos_y, [95:64] delta_x_sum, [127:96] delta_y_sum,
  // [130:128] button_bits, [131] had_motion, [135:132] zero
  logic [135:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  int outstanding, mismatches, reports, moves, drops;

  // Sender pacing: items go out in bursts, with gaps only when idling is enabled
  int unsigned burst_left;
  bit          sender_idles;
  int unsigned items_sent;

  ps2_mouse_packet_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ps2mpt_report_checker i_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches),
    .reports_o     (reports),
    .moves_o       (moves),
    .drops_o       (drops)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: switch between stall patterns at random
  initial begin
    int unsigned mode, span, stall;
    m_axis_tready <= 1'b0;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(1));
          2: m_axis_tready <= ($urandom_range(15) != 0);
          default: begin
            // Mostly ready, with an occasional long stall
            if (stall != 0) begin
              stall--;
              m_axis_tready <= 1'b0;
            end else if ($urandom_range(7) == 0) begin
              stall = $urandom_range(4, 20);
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Offer one item and hold it until the block takes it. Drop valid only when a
  // burst ends and a nonzero gap follows, so valid never toggles within a step.
  task automatic push_item(input ps2mpt_pkg::func_e op, input logic [7:0] status,
                           input logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, status};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  // Controller byte flagged as output-full and aux; other status bits random
  task automatic send_mouse_byte(input logic [7:0] data);
    logic [7:0] status;
    status = 8'($urandom_range(255));
    status[ps2mpt_pkg::ST_FULL_BIT] = 1'b1;
    status[ps2mpt_pkg::ST_AUX_BIT]  = 1'b1;
    push_item(ps2mpt_pkg::FUNC_BYTE, status, data);
  endtask

  task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_mouse_byte(head);
    send_mouse_byte(dx);
    send_mouse_byte(dy);
  endtask

  // Commands ignore status and data; randomize them anyway
  task automatic send_cmd(input ps2mpt_pkg::func_e op);
    push_item(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic send_random_cmd();
    send_cmd(ps2mpt_pkg::func_e'($urandom_range(ps2mpt_pkg::FUNC_POLL,
                                                ps2mpt_pkg::FUNC_GET)));
  endtask

  // Hold the sender until every report is back, then let queued bytes and
  // reclamps drain through the back end.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly whole packets with random content; the rest is commands, bytes for
  // the keyboard, stray bytes that force a resync, and truncated packets.
  task automatic run_random(input int unsigned quota);
    int unsigned done_cnt, pick;
    logic [7:0]  head, status;
    done_cnt = 0;
    while (done_cnt < quota) begin
      pick = $urandom_range(99);
      head = 8'($urandom_range(255));
      head[ps2mpt_pkg::SYNC_BIT] = 1'b1;
      if (pick < 62) begin
        // Keep most packets free of overflow bits so they move the cursor
        if ($urandom_range(7) != 0) head = head & ~ps2mpt_pkg::OVF_MASK;
        send_mouse_byte(head);
        if ($urandom_range(19) == 0) send_random_cmd();
        send_mouse_byte(8'($urandom_range(255)));
        send_mouse_byte(8'($urandom_range(255)));
        done_cnt += 3;
      end else if (pick < 84) begin
        send_random_cmd();
        done_cnt++;
      end else if (pick < 92) begin
        // Not a mouse byte: clear output-full or aux (or both)
        status = 8'($urandom_range(255));
        case ($urandom_range(2))
          0: status[ps2mpt_pkg::ST_FULL_BIT] = 1'b0;
          1: status[ps2mpt_pkg::ST_AUX_BIT] = 1'b0;
          default: begin
            status[ps2mpt_pkg::ST_FULL_BIT] = 1'b0;
            status[ps2mpt_pkg::ST_AUX_BIT]  = 1'b0;
          end
        endcase
        push_item(ps2mpt_pkg::FUNC_BYTE, status, 8'($urandom_range(255)));
      end else if (pick < 96) begin
        // Sync bit clear: dropped when it lands on a packet start
        head[ps2mpt_pkg::SYNC_BIT] = 1'b0;
        send_mouse_byte(head);
      end else begin
        send_mouse_byte(head);
        if ($urandom_range(1) != 0) send_mouse_byte(8'($urandom_range(255)));
        done_cnt++;
      end
    end
  endtask

  initial begin
    logic [31:0] pin;
    int unsigned phase;

    burst_left   = 0;
    sender_idles = 1'b1;
    items_sent   = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ps2mpt_pkg::FUNC_BYTE;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= ps2mpt_pkg::CFG_MIN_X;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, ignored bytes, resync, delta extremes, overflow
    send_cmd(ps2mpt_pkg::FUNC_GET);
    send_cmd(ps2mpt_pkg::FUNC_POLL);
    push_item(ps2mpt_pkg::FUNC_BYTE, 8'h20, 8'h08);   // aux without output-full
    push_item(ps2mpt_pkg::FUNC_BYTE, 8'h01, 8'h08);   // output-full, keyboard byte
    send_mouse_byte(8'h07);               // sync bit clear at packet start
    send_packet(8'h09, 8'h7F, 8'h80);     // +127 in x, -128 in y, left button
    send_cmd(ps2mpt_pkg::FUNC_GET);
    send_packet(8'h48, 8'h10, 8'h10);     // x overflow: drop
    send_packet(8'h88, 8'h10, 8'h10);     // y overflow: drop
    send_cmd(ps2mpt_pkg::FUNC_GET);
    send_packet(8'h0F, 8'h80, 8'h7F);     // -128 in x, +127 in y, all buttons
    send_packet(8'h3E, 8'h00, 8'hFF);
    send_cmd(ps2mpt_pkg::FUNC_RECLAMP);   // clamping still off: no change
    send_cmd(ps2mpt_pkg::FUNC_POLL);
    send_cmd(ps2mpt_pkg::FUNC_GET);

    // Random phases, each under its own bounds; pause until idle before writes
    for (phase = 0; phase < PhaseCount; phase++) begin
      quiesce();
      sender_idles = (phase != 4 && phase != 7);
      case (phase)
        0: begin
          write_reg(ps2mpt_pkg::CFG_MIN_X, -100);
          write_reg(ps2mpt_pkg::CFG_MAX_X, 100);
          write_reg(ps2mpt_pkg::CFG_MIN_Y, -50);
          write_reg(ps2mpt_pkg::CFG_MAX_Y, 50);
        end
        1: begin
          // Widest window: clamping on, but never binding
          write_reg(ps2mpt_pkg::CFG_MIN_X, 32'h8000_0000);
          write_reg(ps2mpt_pkg::CFG_MAX_X, 32'h7FFF_FFFF);
          write_reg(ps2mpt_pkg::CFG_MIN_Y, 32'h8000_0000);
          write_reg(ps2mpt_pkg::CFG_MAX_Y, 32'h7FFF_FFFF);
        end
        2: begin
          // Park the cursor near both ends of the range, then free it so the
          // walk hits saturation
          write_reg(ps2mpt_pkg::CFG_MIN_X, 32'h7FFF_FF80);
          write_reg(ps2mpt_pkg::CFG_MAX_X, 32'h7FFF_FF80);
          write_reg(ps2mpt_pkg::CFG_MIN_Y, 32'h8000_0040);
          write_reg(ps2mpt_pkg::CFG_MAX_Y, 32'h8000_0040);
          send_cmd(ps2mpt_pkg::FUNC_RECLAMP);
          quiesce();
          write_reg(ps2mpt_pkg::CFG_MAX_X, 32'h8000_0000);
          write_reg(ps2mpt_pkg::CFG_MIN_Y, 32'h7FFF_FFFF);
        end
        3: begin
          // Window of one point on each axis
          pin = $urandom_range(600) - 300;
          write_reg(ps2mpt_pkg::CFG_MIN_X, pin);
          write_reg(ps2mpt_pkg::CFG_MAX_X, pin);
          write_reg(ps2mpt_pkg::CFG_MIN_Y, 32'h7FFF_FFFF);
          write_reg(ps2mpt_pkg::CFG_MAX_Y, 32'h7FFF_FFFF);
        end
        4: begin
          write_reg(ps2mpt_pkg::CFG_MIN_X, 0);
          write_reg(ps2mpt_pkg::CFG_MIN_Y, 0);
          write_reg(ps2mpt_pkg::CFG_MAX_X, -1);
          write_reg(ps2mpt_pkg::CFG_MAX_Y, -1);
        end
        default: begin
          // Small windows mostly, full-range values sometimes; either order
          write_reg(ps2mpt_pkg::CFG_MIN_X,
                    ($urandom_range(3) == 0) ? $urandom() : $urandom_range(600) - 300);
          write_reg(ps2mpt_pkg::CFG_MIN_Y,
                    ($urandom_range(3) == 0) ? $urandom() : $urandom_range(600) - 300);
          write_reg(ps2mpt_pkg::CFG_MAX_X,
                    ($urandom_range(3) == 0) ? $urandom() : $urandom_range(600) - 300);
          write_reg(ps2mpt_pkg::CFG_MAX_Y,
                    ($urandom_range(3) == 0) ? $urandom() : $urandom_range(600) - 300);
          // Index past the last register: must be ignored
          write_reg(8'($urandom_range(ps2mpt_pkg::CFG_MAX_Y + 1, 255)), $urandom());
        end
      endcase
      run_random(PhaseItems);
      send_cmd(ps2mpt_pkg::FUNC_GET);
    end

    // Drain, then give the pipeline time to show any stray result
    quiesce();
    repeat (10) @(posedge clk_i);

    $display("covered %0d items across %0d bound settings plus reset bounds", items_sent,
             PhaseCount);
    $display("%0d packets moved the cursor, %0d overflow packets dropped, %0d reports checked",
             moves, drops, reports);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
